/* rtl/assert_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros shared by the PWM RTL
// Clocked, reset-qualified concurrent assertion wrappers.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge outside reset.
`define SPWM_ASSERT(label, clk, rstn, prop) \
    label: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error("spwm assertion failed");

// Condition must never be true outside reset.
`define SPWM_NEVER(label, clk, rstn, cond) \
    label: assert property (@(posedge clk) disable iff (!rstn) !(cond)) \
        else $error("spwm forbidden condition seen");

`endif

/* rtl/spwm_pkg.sv */
// ----------------------------------------------------------------------------
// spwm_pkg
// Types and constants for the multichannel soft PWM.
// ----------------------------------------------------------------------------
`default_nettype none

package spwm_pkg;

    localparam int CHANNELS  = 8;
    localparam int PINS      = 8;
    localparam int LIVE      = (CHANNELS < PINS) ? CHANNELS : PINS;

    localparam int CH_W      = 3;
    localparam int DUTY_W    = 7;
    localparam int FREQ_W    = 8;
    localparam int ELAPSED_W = 11;
    localparam int LIMIT_W   = 10;
    localparam int PROD_W    = ELAPSED_W + FREQ_W;

    localparam logic [DUTY_W-1:0]    DUTY_MAX    = DUTY_W'(100);
    localparam logic [FREQ_W-1:0]    FREQ_MAX    = FREQ_W'(200);
    localparam logic [ELAPSED_W-1:0] ELAPSED_MAX = '1;
    localparam logic [LIMIT_W-1:0]   LIMIT_SCALE = LIMIT_W'(10);

    typedef enum logic [1:0] {
        KIND_TICK  = 2'd0,
        KIND_SET   = 2'd1,
        KIND_WRITE = 2'd2,
        KIND_NONE  = 2'd3
    } kind_t;

    typedef struct packed {
        kind_t             kind;
        logic [CH_W-1:0]   channel;
        logic [7:0]        duty_percent;
        logic [7:0]        freq_hz;
        logic              level;
    } in_item_t;

    typedef struct packed {
        logic [PINS-1:0] pin_levels;
        logic [PINS-1:0] active_mask;
    } out_item_t;

    // Per-channel command from the decoder
    typedef struct packed {
        logic              tick;
        logic              load;
        logic [DUTY_W-1:0] duty;
        logic [FREQ_W-1:0] freq;
    } lane_ctl_t;

    // Per-channel status back to the pin logic
    typedef struct packed {
        logic toggle;
        logic force_low;
        logic running_next;
    } lane_stat_t;

endpackage

`default_nettype wire

/* rtl/spwm_lane.sv */
// ----------------------------------------------------------------------------
// spwm_lane
// One PWM channel: duty/frequency store, millisecond counter, phase test.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module spwm_lane (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire spwm_pkg::lane_ctl_t ctl,
    input  wire logic                pin_high,
    output spwm_pkg::lane_stat_t     stat
);
    import spwm_pkg::*;

    logic [DUTY_W-1:0]    duty_reg,    duty_next;
    logic [FREQ_W-1:0]    freq_reg,    freq_next;
    logic [ELAPSED_W-1:0] elapsed_reg, elapsed_next;

    logic                 running;
    logic [ELAPSED_W-1:0] elapsed_inc;
    logic [LIMIT_W-1:0]   limit;
    logic [PROD_W-1:0]    product;
    logic                 reached;

    always_comb
    begin
        running     = (freq_reg != '0) && (duty_reg != '0);
        elapsed_inc = (elapsed_reg == ELAPSED_MAX) ? elapsed_reg
                                                   : elapsed_reg + ELAPSED_W'(1);
        // high phase lasts 10*duty, low phase 10*(100-duty), scaled by freq
        limit   = pin_high ? LIMIT_W'(duty_reg) * LIMIT_SCALE
                           : LIMIT_W'(DUTY_MAX - duty_reg) * LIMIT_SCALE;
        product = PROD_W'(elapsed_inc) * PROD_W'(freq_reg);
        reached = product >= PROD_W'(limit);
    end

    always_comb
    begin
        duty_next    = duty_reg;
        freq_next    = freq_reg;
        elapsed_next = elapsed_reg;
        if (ctl.load)
        begin
            duty_next = ctl.duty;
            freq_next = ctl.freq;
        end
        else if (ctl.tick && running)
        begin
            elapsed_next = reached ? '0 : elapsed_inc;
        end
    end

    always_comb
    begin
        stat.toggle       = ctl.tick && running && reached;
        stat.force_low    = ctl.load && (ctl.freq == '0);
        stat.running_next = (freq_next != '0) && (duty_next != '0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            duty_reg    <= '0;
            freq_reg    <= '0;
            elapsed_reg <= '0;
        end
        else
        begin
            duty_reg    <= duty_next;
            freq_reg    <= freq_next;
            elapsed_reg <= elapsed_next;
        end
    end

    `SPWM_NEVER(a_toggle_only_running, clk, rst_n, stat.toggle && !running)
    `SPWM_ASSERT(a_toggle_clears_count, clk, rst_n, stat.toggle |=> elapsed_reg == '0)

endmodule

`default_nettype wire

/* rtl/multichannel_soft_pwm_top.sv */
// ----------------------------------------------------------------------------
// multichannel_soft_pwm_top
// Eight-channel millisecond PWM driving an output byte.
// ----------------------------------------------------------------------------
// Path: an accepted item passes the input register, then the result register;
//   a result held back by result_ready low stalls the item in between.
// Throughput: one item per cycle unless the output stalls; the per-channel
//   multiply and compare all sit between the input and result registers.
// Reset: rst_n clears pins, duty, frequency and counters of every channel.
`default_nettype none
`include "assert_macros.svh"

module multichannel_soft_pwm_top (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                item_valid,
    output logic                     item_ready,
    input  wire spwm_pkg::in_item_t  item,
    output logic                     result_valid,
    input  wire logic                result_ready,
    output spwm_pkg::out_item_t      result
);
    import spwm_pkg::*;

    in_item_t        item_reg;
    logic            item_valid_reg;
    out_item_t       result_reg;
    logic            result_valid_reg;
    logic [PINS-1:0] levels_reg, levels_next;

    logic advance;
    logic fire;
    logic is_tick, is_set, is_write;

    logic [DUTY_W-1:0] duty_clamped;
    logic [FREQ_W-1:0] freq_clamped;

    lane_ctl_t  ctl  [LIVE];
    lane_stat_t stat [LIVE];

    logic [PINS-1:0] toggle_vec;
    logic [PINS-1:0] force_vec;
    logic [PINS-1:0] mask_next;

    assign advance    = !result_valid_reg || result_ready;
    assign fire       = item_valid_reg && advance;
    assign item_ready = !item_valid_reg || advance;

    always_comb
    begin
        is_tick  = 1'b0;
        is_set   = 1'b0;
        is_write = 1'b0;
        unique case (item_reg.kind)
            KIND_TICK:  is_tick  = 1'b1;
            KIND_SET:   is_set   = 1'b1;
            KIND_WRITE: is_write = 1'b1;
            default:    ;
        endcase
    end

    always_comb
    begin
        duty_clamped = (item_reg.duty_percent > 8'(DUTY_MAX)) ? DUTY_MAX
                                                              : DUTY_W'(item_reg.duty_percent);
        freq_clamped = (item_reg.freq_hz > FREQ_MAX) ? FREQ_MAX : item_reg.freq_hz;
    end

    for (genvar n = 0; n < LIVE; n++)
    begin : g_lane
        always_comb
        begin
            ctl[n].tick = fire && is_tick;
            ctl[n].load = fire && is_set && (item_reg.channel == CH_W'(n));
            ctl[n].duty = duty_clamped;
            ctl[n].freq = freq_clamped;
        end

        spwm_lane u_lane (
            .clk      (clk),
            .rst_n    (rst_n),
            .ctl      (ctl[n]),
            .pin_high (levels_reg[n]),
            .stat     (stat[n])
        );
    end

    always_comb
    begin
        toggle_vec = '0;
        force_vec  = '0;
        mask_next  = '0;
        for (int n = 0; n < LIVE; n++)
        begin
            toggle_vec[n] = stat[n].toggle;
            force_vec[n]  = stat[n].force_low;
            mask_next[n]  = stat[n].running_next;
        end
        // tick toggles and set-with-zero-frequency never coincide
        levels_next = (levels_reg ^ toggle_vec) & ~force_vec;
        if (fire && is_write)
        begin
            levels_next[item_reg.channel] = item_reg.level;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg   <= 1'b0;
            result_valid_reg <= 1'b0;
            levels_reg       <= '0;
        end
        else
        begin
            if (item_ready)
                item_valid_reg <= item_valid;
            if (fire)
            begin
                result_valid_reg <= 1'b1;
                levels_reg       <= levels_next;
            end
            else if (result_ready)
            begin
                result_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers: no reset
    always_ff @(posedge clk)
    begin
        if (item_valid && item_ready)
            item_reg <= item;
        if (fire)
        begin
            result_reg.pin_levels  <= levels_next;
            result_reg.active_mask <= mask_next;
        end
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    `SPWM_ASSERT(a_ready_when_empty, clk, rst_n, !result_valid_reg |-> item_ready)
    `SPWM_ASSERT(a_write_lands, clk, rst_n,
        (fire && is_write) |=> result_reg.pin_levels[$past(item_reg.channel)] ==
        $past(item_reg.level))
    `SPWM_ASSERT(a_none_holds_pins, clk, rst_n,
        (fire && !is_tick && !is_set && !is_write) |=> levels_reg == $past(levels_reg))
    `SPWM_NEVER(a_mask_in_range, clk, rst_n, fire && ((mask_next >> LIVE) != '0))

endmodule

`default_nettype wire

/* tb/tb.sv */
// ----------------------------------------------------------------------------
// tb: multichannel_soft_pwm_top testbench
// Streams millisecond ticks, channel setups, direct pin writes and no-op items
// through the valid/ready input channel. A shadow copy of the eight PWM lanes is updated
// for every accepted transaction. Each returned pin byte and running mask is
// checked against the oldest pending prediction. Both sides stall at random until the calm phase.
// ----------------------------------------------------------------------------
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import spwm_pkg::*;

    localparam int STALL_LIMIT  = 2000;
    localparam int RANDOM_ITEMS = 400;
    localparam int CALM_FROM    = 340;
    localparam int DRAIN_AT     = 200;

    // Shadow of the PWM lanes plus the queue of pin bytes still owed by the DUT
    class pwm_scoreboard;
        logic [PINS-1:0]      pins;
        logic [DUTY_W-1:0]    duty_set [CHANNELS];
        logic [FREQ_W-1:0]    freq_set [CHANNELS];
        logic [ELAPSED_W-1:0] ms_count [CHANNELS];
        out_item_t            expected_pins [$];
        int                   errors;

        function new();
            pins   = '0;
            errors = 0;
            for (int n = 0; n < CHANNELS; n++)
            begin
                duty_set[n] = '0;
                freq_set[n] = '0;
                ms_count[n] = '0;
            end
        endfunction

        function void note_item(in_item_t it);
            out_item_t want;
            logic      on;
            int        lim;
            case (it.kind)
                KIND_TICK:
                begin
                    for (int n = 0; n < LIVE; n++)
                    begin
                        // idle lanes hold both pin and count
                        if (freq_set[n] != '0 && duty_set[n] != '0)
                        begin
                            on = pins[n];
                            if (ms_count[n] != ELAPSED_MAX)
                                ms_count[n] = ms_count[n] + 1'b1;
                            lim = on ? 10 * int'(duty_set[n])
                                     : 10 * (int'(DUTY_MAX) - int'(duty_set[n]));
                            if (int'(ms_count[n]) * int'(freq_set[n]) >= lim)
                            begin
                                pins[n]     = !on;
                                ms_count[n] = '0;
                            end
                        end
                    end
                end
                KIND_SET:
                begin
                    if (int'(it.channel) < CHANNELS)
                    begin
                        duty_set[it.channel] = (it.duty_percent > DUTY_MAX) ?
                                               DUTY_MAX : it.duty_percent[DUTY_W-1:0];
                        freq_set[it.channel] = (it.freq_hz > FREQ_MAX) ?
                                               FREQ_MAX : it.freq_hz;
                        if (freq_set[it.channel] == '0)
                            pins[it.channel] = 1'b0;
                    end
                end
                KIND_WRITE:
                    pins[it.channel] = it.level;
                default:
                    ;
            endcase
            want.pin_levels  = pins;
            want.active_mask = '0;
            for (int n = 0; n < LIVE; n++)
                if (freq_set[n] != '0 && duty_set[n] != '0)
                    want.active_mask[n] = 1'b1;
            expected_pins.push_back(want);
        endfunction

        function void check_result(out_item_t got);
            out_item_t want;
            if (expected_pins.size() == 0)
            begin
                errors++;
                $error("unexpected result transaction: pin_levels %02h active_mask %02h",
                       got.pin_levels, got.active_mask);
                return;
            end
            want = expected_pins.pop_front();
            if (got.pin_levels !== want.pin_levels)
            begin
                errors++;
                $error("pin_levels: expected %02h, actual %02h",
                       want.pin_levels, got.pin_levels);
            end
            if (got.active_mask !== want.active_mask)
            begin
                errors++;
                $error("active_mask: expected %02h, actual %02h",
                       want.active_mask, got.active_mask);
            end
        endfunction
    endclass

    logic      clk;
    logic      rst_n;
    logic      item_valid;
    logic      item_ready;
    in_item_t  item;
    logic      result_valid;
    logic      result_ready;
    out_item_t result;

    bit            calm = 1'b0;
    int            quiet_cycles = 0;
    pwm_scoreboard sb = new();

    multichannel_soft_pwm_top dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .item         (item),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    function automatic in_item_t make_item(kind_t k, int ch, int duty, int freq, bit lvl);
        in_item_t it;
        it.kind         = k;
        it.channel      = CH_W'(ch);
        it.duty_percent = 8'(duty);
        it.freq_hz      = 8'(freq);
        it.level        = lvl;
        return it;
    endfunction

    function automatic in_item_t random_item();
        in_item_t it;
        int       pick;
        int       shape;
        it = make_item(KIND_TICK, $urandom_range(0, 7), $urandom_range(0, 255),
                       $urandom_range(0, 255), 1'($urandom_range(0, 1)));
        pick = $urandom_range(0, 99);
        if (pick < 68)
            it.kind = KIND_TICK;
        else if (pick < 84)
        begin
            it.kind = KIND_SET;
            shape   = $urandom_range(0, 9);
            // mostly fast lanes so pins toggle within a few ticks
            if (shape < 6)
            begin
                it.freq_hz      = 8'($urandom_range(100, 255));
                it.duty_percent = 8'($urandom_range(1, 110));
            end
            else if (shape == 8)
                it.freq_hz = '0;
            else if (shape == 9)
                it.duty_percent = '0;
        end
        else if (pick < 96)
            it.kind = KIND_WRITE;
        else
            it.kind = KIND_NONE;
        return it;
    endfunction

    // Hold valid and payload until the transaction is taken
    task automatic send_item(input in_item_t it);
        if (!calm && $urandom_range(0, 4) == 0)
        begin
            item_valid <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge clk);
        end
        item_valid <= 1'b1;
        item       <= it;
        do
            @(posedge clk);
        while (!item_ready);
    endtask

    task automatic drain_results();
        while (sb.expected_pins.size() != 0)
            @(posedge clk);
    endtask

    initial
    begin : sink_ready
        result_ready = 1'b0;
        @(posedge clk);
        forever
        begin
            if (!calm && $urandom_range(0, 2) == 0)
            begin
                result_ready <= 1'b0;
                repeat ($urandom_range(1, 14)) @(posedge clk);
            end
            else
            begin
                result_ready <= 1'b1;
                repeat ($urandom_range(1, 24)) @(posedge clk);
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (item_valid && item_ready)
                sb.note_item(item);
            if (result_valid && result_ready)
                sb.check_result(result);
            if ((item_valid && item_ready) || (result_valid && result_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles == STALL_LIMIT)
            begin
                $display("multichannel_soft_pwm_top verification failed");
                $finish;
            end
        end
    end

    initial
    begin : stimulus
        in_item_t plan [$];
        rst_n      = 1'b0;
        item_valid = 1'b0;
        item       = '0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // idle lanes at reset, then the unused kind with every bit set
        plan.push_back(make_item(KIND_TICK, 0, 0, 0, 0));
        plan.push_back(make_item(KIND_NONE, 7, 255, 255, 1));
        // clamped setup gives full duty: low pin rises on the next tick
        plan.push_back(make_item(KIND_SET, 0, 255, 255, 0));
        repeat (7) plan.push_back(make_item(KIND_TICK, 0, 0, 0, 0));
        plan.push_back(make_item(KIND_SET, 7, 1, 1, 0));
        plan.push_back(make_item(KIND_SET, 3, 50, 200, 0));
        repeat (3) plan.push_back(make_item(KIND_TICK, 0, 0, 0, 0));
        plan.push_back(make_item(KIND_WRITE, 5, 0, 0, 1));
        plan.push_back(make_item(KIND_WRITE, 5, 0, 0, 0));
        plan.push_back(make_item(KIND_WRITE, 2, 0, 0, 1));
        // zero frequency drops the pin; zero duty parks the lane with its count
        plan.push_back(make_item(KIND_SET, 0, 100, 0, 1));
        plan.push_back(make_item(KIND_SET, 3, 0, 100, 0));
        plan.push_back(make_item(KIND_TICK, 0, 0, 0, 0));
        plan.push_back(make_item(KIND_SET, 3, 50, 200, 0));
        plan.push_back(make_item(KIND_TICK, 0, 0, 0, 0));
        plan.push_back(make_item(KIND_WRITE, 7, 255, 255, 1));

        foreach (plan[i])
            send_item(plan[i]);
        item_valid <= 1'b0;
        drain_results();

        for (int i = 0; i < RANDOM_ITEMS; i++)
        begin
            if (i == DRAIN_AT)
            begin
                item_valid <= 1'b0;
                drain_results();
            end
            if (i == CALM_FROM)
                calm = 1'b1;
            send_item(random_item());
        end
        item_valid <= 1'b0;
        drain_results();
        repeat (8) @(posedge clk);

        if (sb.errors == 0 && sb.expected_pins.size() == 0)
            $display("multichannel_soft_pwm_top verification clean");
        else
            $display("multichannel_soft_pwm_top verification failed");
        $finish;
    end
endmodule

/* files.f */
+incdir+rtl
rtl/spwm_pkg.sv
rtl/spwm_lane.sv
rtl/multichannel_soft_pwm_top.sv
tb/tb.sv
